// File: rtl/vnr_pkg.sv
// Shared constants, operation codes and the sideband type of the vector normalize/rotate unit.
package vnr_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned SINE_TABLE_ENTRIES_DEF = 256;
  localparam int unsigned FRACTION_BITS_DEF      = 16;

  // Operation codes carried on in_op.
  localparam logic [1:0] OP_NORMALIZE = 2'd0;
  localparam logic [1:0] OP_ROT_X     = 2'd1;
  localparam logic [1:0] OP_ROT_Y     = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  // Trig constants in Q2.30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TRIG_ONE    = 64'd1073741824;

  // Data that rides along the root and quotient pipelines. For a normalize the
  // components are the input vector; otherwise they are the finished result.
  typedef struct packed {
    logic        is_norm;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vnr_side_t;

endpackage

// File: rtl/vnr_front.sv
// Front pipeline: squares and their sum, sine/cosine lookup and the planar rotation.
module vnr_front #(
  parameter int unsigned SINE_TABLE_ENTRIES = vnr_pkg::SINE_TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  input  logic [15:0]         in_angle,
  output logic                out_valid,
  output logic [63:0]         out_rad,
  output vnr_pkg::vnr_side_t  out_side
);

  localparam int unsigned IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int unsigned PW    = 14 + IDX_W;
  localparam logic [63:0] HALF_LSB = 64'd536870912;
  localparam logic signed [63:0] RND_POS = 64'sd536870912;
  localparam logic signed [63:0] RND_NEG = 64'sd536870911;

  // Quarter-wave sine entry k in Q2.30, evaluated at elaboration.
  function automatic logic [30:0] sine_entry(input int unsigned k);
    logic [63:0]        xq;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    xq = (64'(k) * vnr_pkg::HALF_PI_Q30 + 64'(SINE_TABLE_ENTRIES / 2)) / SINE_TABLE_ENTRIES;
    x2 = (xq * xq + HALF_LSB) >> 30;
    term = xq;
    acc = $signed(xq);
    term = ((term * x2 + HALF_LSB) >> 30) / 64'd6;   acc = acc - $signed(term);
    term = ((term * x2 + HALF_LSB) >> 30) / 64'd20;  acc = acc + $signed(term);
    term = ((term * x2 + HALF_LSB) >> 30) / 64'd42;  acc = acc - $signed(term);
    term = ((term * x2 + HALF_LSB) >> 30) / 64'd72;  acc = acc + $signed(term);
    term = ((term * x2 + HALF_LSB) >> 30) / 64'd110; acc = acc - $signed(term);
    term = ((term * x2 + HALF_LSB) >> 30) / 64'd156; acc = acc + $signed(term);
    term = ((term * x2 + HALF_LSB) >> 30) / 64'd210; acc = acc - $signed(term);
    term = ((term * x2 + HALF_LSB) >> 30) / 64'd272; acc = acc + $signed(term);
    if (acc < 0) acc = '0;
    if (acc > $signed(vnr_pkg::TRIG_ONE)) acc = $signed(vnr_pkg::TRIG_ONE);
    return acc[30:0];
  endfunction

  // Table index for a binary angle; odd quadrants run the table backwards.
  function automatic logic [IDX_W-1:0] lut_index(input logic [15:0] a);
    logic [PW-1:0]    scaled;
    logic [IDX_W-1:0] idx;
    scaled = PW'(a[13:0]) * PW'(SINE_TABLE_ENTRIES) + PW'(8192);
    idx = IDX_W'(scaled >> 14);
    if (a[14]) idx = IDX_W'(SINE_TABLE_ENTRIES) - idx;
    return idx;
  endfunction

  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    if (!v[33] && (v[32] || v[31])) return 32'h7FFF_FFFF;
    if (v[33] && !(v[32] && v[31])) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [15:0] in_angle_d(input logic [15:0] a);
    return a + 16'h4000;
  endfunction

  logic [30:0] sine_rom [0:SINE_TABLE_ENTRIES];

  for (genvar g = 0; g <= SINE_TABLE_ENTRIES; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g);
  end

  // Stage 0: input capture.
  logic               v0_r;
  logic [1:0]         op0_r;
  logic signed [31:0] x0_r, y0_r, z0_r;
  logic [15:0]        ang0_r;
  // Stage 1: squares and table indexes.
  logic               v1_r;
  logic [1:0]         op1_r;
  logic signed [31:0] x1_r, y1_r, z1_r;
  logic signed [63:0] xx1_r, yy1_r, zz1_r;
  logic [IDX_W-1:0]   sidx1_r, cidx1_r;
  logic               sneg1_r, cneg1_r;
  // Stage 2: partial sum and signed sine/cosine.
  logic               v2_r;
  logic [1:0]         op2_r;
  logic signed [31:0] x2_r, y2_r, z2_r;
  logic [63:0]        sxy2_r, zz2_r;
  logic signed [31:0] sin2_r, cos2_r;
  // Stage 3: full sum and the four products.
  logic               v3_r;
  logic [1:0]         op3_r;
  logic signed [31:0] x3_r, y3_r, z3_r;
  logic [63:0]        rad3_r;
  logic signed [63:0] m0_r, m1_r, m2_r, m3_r;
  // Stage 4: rotated pair before rounding.
  logic               v4_r;
  logic [1:0]         op4_r;
  logic signed [31:0] x4_r, y4_r, z4_r;
  logic [63:0]        rad4_r;
  logic signed [63:0] p4_r, q4_r;
  // Stage 5: rounded pair.
  logic               v5_r;
  logic [1:0]         op5_r;
  logic signed [31:0] x5_r, y5_r, z5_r;
  logic [63:0]        rad5_r;
  logic signed [33:0] pr5_r, qr5_r;
  // Stage 6: output.
  logic               v6_r;
  logic [63:0]        rad6_r;
  vnr_pkg::vnr_side_t side6_r;

  logic [15:0]        cos_ang;
  logic signed [31:0] rot_u;
  logic signed [63:0] p_adj, q_adj;
  vnr_pkg::vnr_side_t side_nxt;

  assign cos_ang = in_angle_d(ang0_r);
  assign rot_u   = (op2_r == vnr_pkg::OP_ROT_X) ? y2_r : x2_r;
  assign p_adj   = p4_r + (p4_r[63] ? RND_NEG : RND_POS);
  assign q_adj   = q4_r + (q4_r[63] ? RND_NEG : RND_POS);

  always_comb begin
    side_nxt.is_norm = (op5_r == vnr_pkg::OP_NORMALIZE);
    side_nxt.x = x5_r;
    side_nxt.y = y5_r;
    side_nxt.z = z5_r;
    case (op5_r)
      vnr_pkg::OP_ROT_X: begin
        side_nxt.y = sat34(pr5_r);
        side_nxt.z = sat34(qr5_r);
      end
      vnr_pkg::OP_ROT_Y: begin
        side_nxt.x = sat34(pr5_r);
        side_nxt.z = sat34(qr5_r);
      end
      default: begin
        side_nxt.x = x5_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    op0_r  <= in_op;
    x0_r   <= in_x;
    y0_r   <= in_y;
    z0_r   <= in_z;
    ang0_r <= in_angle;

    op1_r   <= op0_r;
    x1_r    <= x0_r;
    y1_r    <= y0_r;
    z1_r    <= z0_r;
    xx1_r   <= x0_r * x0_r;
    yy1_r   <= y0_r * y0_r;
    zz1_r   <= z0_r * z0_r;
    sidx1_r <= lut_index(ang0_r);
    cidx1_r <= lut_index(cos_ang);
    sneg1_r <= ang0_r[15];
    cneg1_r <= cos_ang[15];

    op2_r  <= op1_r;
    x2_r   <= x1_r;
    y2_r   <= y1_r;
    z2_r   <= z1_r;
    sxy2_r <= $unsigned(xx1_r) + $unsigned(yy1_r);
    zz2_r  <= $unsigned(zz1_r);
    sin2_r <= sneg1_r ? -$signed({1'b0, sine_rom[sidx1_r]}) : $signed({1'b0, sine_rom[sidx1_r]});
    cos2_r <= cneg1_r ? -$signed({1'b0, sine_rom[cidx1_r]}) : $signed({1'b0, sine_rom[cidx1_r]});

    op3_r  <= op2_r;
    x3_r   <= x2_r;
    y3_r   <= y2_r;
    z3_r   <= z2_r;
    rad3_r <= sxy2_r + zz2_r;
    m0_r   <= cos2_r * rot_u;
    m1_r   <= sin2_r * z2_r;
    m2_r   <= sin2_r * rot_u;
    m3_r   <= cos2_r * z2_r;

    op4_r  <= op3_r;
    x4_r   <= x3_r;
    y4_r   <= y3_r;
    z4_r   <= z3_r;
    rad4_r <= rad3_r;
    if (op3_r == vnr_pkg::OP_ROT_X) begin
      p4_r <= m0_r - m1_r;
      q4_r <= m3_r + m2_r;
    end else begin
      p4_r <= m0_r + m1_r;
      q4_r <= m3_r - m2_r;
    end

    op5_r  <= op4_r;
    x5_r   <= x4_r;
    y5_r   <= y4_r;
    z5_r   <= z4_r;
    rad5_r <= rad4_r;
    pr5_r  <= p_adj[63:30];
    qr5_r  <= q_adj[63:30];

    rad6_r  <= rad5_r;
    side6_r <= side_nxt;
  end

  assign out_valid = v6_r;
  assign out_rad   = rad6_r;
  assign out_side  = side6_r;

endmodule

// File: rtl/vnr_sqrt.sv
// Pipelined floor square root of a 64-bit radicand, one root bit per stage.
module vnr_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [63:0]         in_rad,
  input  vnr_pkg::vnr_side_t  in_side,
  output logic                out_valid,
  output logic [31:0]         out_root,
  output vnr_pkg::vnr_side_t  out_side
);

  logic               vld_r  [1:32];
  logic [31:0]        root_r [1:32];
  vnr_pkg::vnr_side_t side_r [1:32];
  logic [32:0]        rem_r  [1:31];
  logic [63:0]        rad_r  [1:31];

  for (genvar k = 0; k < 32; k++) begin : g_step
    logic               v_i;
    logic [32:0]        rem_i;
    logic [31:0]        root_i;
    logic [63:0]        rad_i;
    vnr_pkg::vnr_side_t side_i;
    logic [34:0]        r_sh;
    logic [34:0]        trial;
    logic [34:0]        diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = vld_r[k];
      assign rem_i  = rem_r[k];
      assign root_i = root_r[k];
      assign rad_i  = rad_r[k];
      assign side_i = side_r[k];
    end

    // Bring down two radicand bits and try the next root bit.
    assign r_sh  = {rem_i, rad_i[63:62]};
    assign trial = {1'b0, root_i, 2'b01};
    assign diff  = r_sh - trial;
    assign ge    = (r_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      root_r[k+1] <= {root_i[30:0], ge};
      side_r[k+1] <= side_i;
    end

    if (k < 31) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k+1] <= ge ? diff[32:0] : r_sh[32:0];
        rad_r[k+1] <= {rad_i[61:0], 2'b00};
      end
    end
  end

  assign out_valid = vld_r[32];
  assign out_root  = root_r[32];
  assign out_side  = side_r[32];

  a_sqrt_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid, 32))
    else $error("root stage valid without an entry 32 cycles earlier");

endmodule

// File: rtl/vnr_div.sv
// Three-lane pipelined divider for the unit vector, with the final select and output registers.
module vnr_div #(
  parameter int unsigned FRACTION_BITS = vnr_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [31:0]         in_mag,
  input  vnr_pkg::vnr_side_t  in_side,
  output logic                out_valid,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic [31:0]         out_magnitude,
  output logic                out_nonzero
);

  localparam int unsigned NW = 32 + FRACTION_BITS;

  // Quotient clamped so that the signed result saturates.
  function automatic logic [31:0] sat_quot(input logic [NW-1:0] q, input logic neg);
    logic ovf;
    ovf = (|q[NW-1:32]) | q[31];
    if (neg) return ovf ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    return ovf ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  logic               vld_r  [0:NW];
  logic [31:0]        mag_r  [0:NW];
  vnr_pkg::vnr_side_t side_r [0:NW];
  logic [NW-1:0]      nq_r   [0:2][0:NW];
  logic [31:0]        rem_r  [0:2][1:NW-1];
  logic [31:0]        comp_in [0:2];
  logic [31:0]        comp_out [0:2];
  logic [31:0]        res [0:2];

  logic               out_valid_r;
  logic [31:0]        out_x_r, out_y_r, out_z_r, out_mag_r;
  logic               out_nz_r;
  logic               divided;

  assign comp_in[0]  = in_side.x;
  assign comp_in[1]  = in_side.y;
  assign comp_in[2]  = in_side.z;
  assign comp_out[0] = side_r[NW].x;
  assign comp_out[1] = side_r[NW].y;
  assign comp_out[2] = side_r[NW].z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    mag_r[0]  <= in_mag;
    side_r[0] <= in_side;
  end

  for (genvar s = 1; s <= NW; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      mag_r[s]  <= mag_r[s-1];
      side_r[s] <= side_r[s-1];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [31:0] a;

    // Numerator is |c| scaled up, plus half the divisor for rounding.
    assign a = comp_in[l][31] ? (~comp_in[l] + 32'd1) : comp_in[l];

    always_ff @(posedge clk) begin
      nq_r[l][0] <= {a, {FRACTION_BITS{1'b0}}} + NW'(in_mag[31:1]);
    end

    for (genvar s = 1; s <= NW; s++) begin : g_step
      logic [31:0] rem_i;
      logic [32:0] r_sh;
      logic [32:0] diff;
      logic        ge;

      if (s == 1) begin : g_first
        assign rem_i = '0;
      end else begin : g_next
        assign rem_i = rem_r[l][s-1];
      end

      assign r_sh = {rem_i, nq_r[l][s-1][NW-1]};
      assign diff = r_sh - {1'b0, mag_r[s-1]};
      assign ge   = (r_sh >= {1'b0, mag_r[s-1]});

      always_ff @(posedge clk) begin
        nq_r[l][s] <= {nq_r[l][s-1][NW-2:0], ge};
      end

      if (s < NW) begin : g_rem
        always_ff @(posedge clk) begin
          rem_r[l][s] <= ge ? diff[31:0] : r_sh[31:0];
        end
      end
    end

    assign res[l] = divided ? sat_quot(nq_r[l][NW], comp_out[l][31]) : comp_out[l];
  end

  assign divided = side_r[NW].is_norm && (mag_r[NW] != 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    out_x_r   <= res[0];
    out_y_r   <= res[1];
    out_z_r   <= res[2];
    out_mag_r <= side_r[NW].is_norm ? mag_r[NW] : 32'd0;
    out_nz_r  <= divided;
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_z         = out_z_r;
  assign out_magnitude = out_mag_r;
  assign out_nonzero   = out_nz_r;

  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid, NW + 2))
    else $error("divider result without an entry at the expected depth");

  a_flag_matches_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nonzero == (out_magnitude != 32'd0)))
    else $error("nonzero flag disagrees with reported length");

endmodule

// File: rtl/vec3_normalize_rotate.sv
// Top level of the vector unit: normalize, or rotate about the X or Y axis.
//
//  Channel  Ports                                   Handshake
//  request  in_op in_x in_y in_z in_angle           start high, busy low at the edge
//  result   out_x out_y out_z out_magnitude         out_strobe high for one cycle
//           out_nonzero
//
// A new beat is taken every cycle; busy never rises. The pipeline is fixed in
// depth: each request passes the 7 front stages, the 32 root stages, the
// 32 + FRACTION_BITS quotient stages and the two capture registers around
// them, and its result is then strobed out.
// Reset is synchronous and clears only the valid bits; beats in flight are dropped.
// The receiver cannot stall, so results are strobed out once and never held back.
module vec3_normalize_rotate #(
  parameter int unsigned SINE_TABLE_ENTRIES = vnr_pkg::SINE_TABLE_ENTRIES_DEF,
  parameter int unsigned FRACTION_BITS      = vnr_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [15:0] in_angle,
  output logic               out_strobe,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [31:0]        out_magnitude,
  output logic               out_nonzero
);

  localparam int unsigned LATENCY = 73 + FRACTION_BITS;

  logic               in_acc;
  logic               fr_valid;
  logic [63:0]        fr_rad;
  vnr_pkg::vnr_side_t fr_side;
  logic               rt_valid;
  logic [31:0]        rt_root;
  vnr_pkg::vnr_side_t rt_side;

  // Every stage advances each cycle, so the unit is always ready.
  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  // Squares and their sum for the length; lookup and rotation for the other codes.
  vnr_front #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_acc),
    .in_op     (in_op),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .in_angle  (in_angle),
    .out_valid (fr_valid),
    .out_rad   (fr_rad),
    .out_side  (fr_side)
  );

  // Length of the vector as the floor square root of the sum of squares.
  vnr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_rad    (fr_rad),
    .in_side   (fr_side),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // Each component over the length, then the choice between that and the
  // pass-through or rotated vector.
  vnr_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (rt_valid),
    .in_mag        (rt_root),
    .in_side       (rt_side),
    .out_valid     (out_strobe),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_magnitude (out_magnitude),
    .out_nonzero   (out_nonzero)
  );

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a request at the pipeline depth");

endmodule

// File: bench/vnr_checker.sv
// Result checker for the vector normalize/rotate unit: predicts each beat and compares.
`timescale 1ns / 1ps
module vnr_checker #(
  parameter int unsigned SINE_TABLE_ENTRIES = vnr_pkg::SINE_TABLE_ENTRIES_DEF,
  parameter int unsigned FRACTION_BITS      = vnr_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [15:0] in_angle,
  input  logic               out_strobe,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic [31:0]        out_magnitude,
  input  logic               out_nonzero,
  output int                 fail_count,
  output int                 pending,
  output int                 vectors_seen
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] mag;
    logic        nz;
  } vec_result_t;

  vec_result_t expected_vectors[$];
  longint      sine_rom[SINE_TABLE_ENTRIES + 1];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Divide by 2^30, rounding half away from zero.
  function automatic longint round_q30(longint v);
    longint unsigned mag_v;
    if (v < 0) begin
      mag_v = -v;
      return -longint'((mag_v + (64'd1 << 29)) >> 30);
    end
    mag_v = v;
    return longint'((mag_v + (64'd1 << 29)) >> 30);
  endfunction

  function automatic longint sine_lookup(logic [15:0] ang);
    longint unsigned idx;
    logic [1:0]      quad;
    quad = ang[15:14];
    idx = (longint'(ang[13:0]) * SINE_TABLE_ENTRIES + 8192) >> 14;
    if (idx > SINE_TABLE_ENTRIES) idx = SINE_TABLE_ENTRIES;
    if (quad[0]) idx = SINE_TABLE_ENTRIES - idx;
    return quad[1] ? -sine_rom[idx] : sine_rom[idx];
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Component divided by the length, rounded to nearest and saturated.
  function automatic logic [31:0] unit_component(longint c, longint unsigned len);
    longint unsigned a, q;
    longint          r;
    a = (c < 0) ? -c : c;
    q = ((a << FRACTION_BITS) + len / 2) / len;
    r = (q > 64'h1_0000_0000) ? 64'sh1_0000_0000 : longint'(q);
    return 32'(clamp32(c < 0 ? -r : r));
  endfunction

  function automatic vec_result_t predict_vector(logic [1:0] op, logic signed [31:0] x,
                                                 logic signed [31:0] y, logic signed [31:0] z,
                                                 logic [15:0] ang);
    vec_result_t     res;
    longint          lx, ly, lz, s, c;
    longint unsigned sq, len;
    lx = x; ly = y; lz = z;
    res = '{x: x, y: y, z: z, mag: 32'd0, nz: 1'b0};
    if (op == vnr_pkg::OP_NORMALIZE) begin
      // The sum of squares wraps at 64 bits, exactly as the unsigned add does.
      sq = longint'(lx * lx) + longint'(ly * ly) + longint'(lz * lz);
      len = floor_sqrt(sq);
      if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
      res.mag = len[31:0];
      if (len != 0) begin
        res.x  = unit_component(lx, len);
        res.y  = unit_component(ly, len);
        res.z  = unit_component(lz, len);
        res.nz = 1'b1;
      end
    end else if (op == vnr_pkg::OP_ROT_X || op == vnr_pkg::OP_ROT_Y) begin
      s = sine_lookup(ang);
      c = sine_lookup(ang + 16'h4000);
      if (op == vnr_pkg::OP_ROT_X) begin
        res.y = 32'(clamp32(round_q30(c * ly - s * lz)));
        res.z = 32'(clamp32(round_q30(s * ly + c * lz)));
      end else begin
        res.x = 32'(clamp32(round_q30(c * lx + s * lz)));
        res.z = 32'(clamp32(round_q30(c * lz - s * lx)));
      end
    end
    return res;
  endfunction

  // Quarter-wave table in Q2.30 from a truncated Taylor series.
  initial begin
    longint unsigned xa, x2, term;
    longint          acc;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      xa = (longint'(k) * vnr_pkg::HALF_PI_Q30 + SINE_TABLE_ENTRIES / 2) / SINE_TABLE_ENTRIES;
      x2 = (xa * xa + (64'd1 << 29)) >> 30;
      term = xa;
      acc = xa;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2 + (64'd1 << 29)) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(vnr_pkg::TRIG_ONE)) acc = vnr_pkg::TRIG_ONE;
      sine_rom[k] = acc;
    end
  end

  initial begin
    fail_count = 0;
    pending = 0;
    vectors_seen = 0;
  end

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    vec_result_t want;
    if (rst_n) begin
      if (start && !busy) begin
        expected_vectors.push_back(predict_vector(in_op, in_x, in_y, in_z, in_angle));
      end
      if (out_strobe) begin
        vectors_seen++;
        if (expected_vectors.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t result beat with nothing expected", $realtime);
        end else begin
          want = expected_vectors.pop_front();
          if (want.x !== out_x) report("out_x", want.x, out_x);
          if (want.y !== out_y) report("out_y", want.y, out_y);
          if (want.z !== out_z) report("out_z", want.z, out_z);
          if (want.mag !== out_magnitude) report("out_magnitude", want.mag, out_magnitude);
          if (want.nz !== out_nonzero) report("out_nonzero", want.nz, out_nonzero);
        end
      end
      pending = expected_vectors.size();
    end
  end
endmodule

// File: bench/tb.sv
// Top of the testbench: clock, reset, request stimulus and the final verdict.
`timescale 1ns / 1ps
module tb;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_op;
  logic signed [31:0] in_x, in_y, in_z;
  logic signed [15:0] in_angle;
  logic               out_strobe;
  logic signed [31:0] out_x, out_y, out_z;
  logic [31:0]        out_magnitude;
  logic               out_nonzero;
  int                 fail_count, pending, vectors_seen;
  int                 idle_pct;

  vec3_normalize_rotate dut (.*);

  // The checker sits beside the block and sees the same ports.
  vnr_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A generous cap on the length of the whole run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Offers one beat and holds it until the block takes it. Busy is sampled
  // on the falling edge so the decision never races the rising edge.
  task automatic send_beat(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [15:0] ang);
    bit taken;
    start    <= 1'b1;
    in_op    <= op;
    in_x     <= x;
    in_y     <= y;
    in_z     <= z;
    in_angle <= ang;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    // Random idle cycles after the beat, at the rate of the current phase.
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Component values that lean toward the edges of the range now and then.
  function automatic logic [31:0] pick_component();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(3) - 1;
      3, 4: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_beats(int count);
    logic [1:0]  op;
    logic [31:0] x, y, z;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(19) == 0) ? vnr_pkg::OP_UNUSED : 2'($urandom_range(2));
      x = pick_component();
      y = pick_component();
      z = pick_component();
      // Occasionally an all-zero vector, so normalize takes its pass-through path.
      if ($urandom_range(15) == 0) {x, y, z} = '0;
      send_beat(op, x, y, z, 16'($urandom));
    end
  endtask

  initial begin
    start    = 1'b0;
    in_op    = vnr_pkg::OP_NORMALIZE;
    in_x     = '0;
    in_y     = '0;
    in_z     = '0;
    in_angle = '0;
    idle_pct = 0;
    rst_n    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: zero vector, extremes, unit axes, the quadrant
    // boundaries of the angle, its extremes and the unused op code.
    send_beat(vnr_pkg::OP_NORMALIZE, 0, 0, 0, 0);
    send_beat(vnr_pkg::OP_NORMALIZE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_beat(vnr_pkg::OP_NORMALIZE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_beat(vnr_pkg::OP_NORMALIZE, 32'h0001_0000, 0, 0, 0);
    send_beat(vnr_pkg::OP_NORMALIZE, 1, 0, 0, 0);
    send_beat(vnr_pkg::OP_NORMALIZE, 32'hFFFF_FFFF, 1, 0, 0);
    send_beat(vnr_pkg::OP_NORMALIZE, 3, 4, 32'h8000_0000, 0);
    send_beat(vnr_pkg::OP_ROT_X, 0, 32'h0001_0000, 0, 16'h0000);
    send_beat(vnr_pkg::OP_ROT_X, 5, 32'h0001_0000, 32'h0002_0000, 16'h4000);
    send_beat(vnr_pkg::OP_ROT_X, 5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000);
    send_beat(vnr_pkg::OP_ROT_X, 5, 32'h8000_0000, 32'h8000_0000, 16'hE000);
    send_beat(vnr_pkg::OP_ROT_X, 5, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
    send_beat(vnr_pkg::OP_ROT_X, 5, 32'h1234_5678, 32'hF000_0000, 16'h7FFF);
    send_beat(vnr_pkg::OP_ROT_Y, 32'h0001_0000, 7, 0, 16'hC000);
    send_beat(vnr_pkg::OP_ROT_Y, 32'h7FFF_FFFF, 7, 32'h7FFF_FFFF, 16'h2000);
    send_beat(vnr_pkg::OP_ROT_Y, 32'h8000_0000, 7, 32'h7FFF_FFFF, 16'h6000);
    send_beat(vnr_pkg::OP_ROT_Y, 32'hFFFF_0000, 7, 32'h0003_0000, 16'h0020);
    send_beat(vnr_pkg::OP_ROT_Y, 32'h0100_0000, 7, 32'h0100_0000, 16'hFFFF);
    send_beat(vnr_pkg::OP_UNUSED, 32'h8000_0000, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 16'h1234);
    send_beat(vnr_pkg::OP_UNUSED, 0, 0, 0, 16'hFFFF);

    // Random beats through phases of back-to-back, heavy and light idling.
    idle_pct = 0;
    random_beats(125);
    idle_pct = 68;
    random_beats(125);

    // Hold off until every result is in, then resume on an empty pipeline.
    start <= 1'b0;
    while (pending != 0) @(posedge clk);

    idle_pct = 34;
    random_beats(125);
    idle_pct = 0;
    random_beats(125);
    start <= 1'b0;

    // Drain: wait for every outstanding result before the verdict.
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("Covered %0d result beats: normalize, rotation about X and Y, the unused op,",
             vectors_seen);
    $display("zero and saturating vectors, and request gaps from none to heavy.");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
